// ===== design/ifp_pkg.sv =====
// Shared types and constants for the IMU frame parser.
`timescale 1ns / 1ps

package ifp_pkg;

    localparam int unsigned FRAME_LEN   = 11;
    localparam int unsigned NUM_PAYLOAD = 8;
    localparam int unsigned FIRST_DATA  = 2;

    localparam logic [7:0] HDR_BYTE   = 8'h55;
    localparam logic [7:0] KIND_ACC   = 8'h51;
    localparam logic [7:0] KIND_GYRO  = 8'h52;
    localparam logic [7:0] KIND_ANGLE = 8'h53;

    localparam logic [3:0] POS_FIRST_DATA = 4'(FIRST_DATA);
    localparam logic [3:0] POS_CHECKSUM   = 4'(FRAME_LEN - 1);

    typedef enum logic [1:0] {
        PH_HUNT = 2'd0,
        PH_TYPE = 2'd1,
        PH_DATA = 2'd2
    } phase_t;

    typedef struct packed {
        logic signed [15:0] word_extra;
        logic signed [15:0] word_z;
        logic signed [15:0] word_y;
        logic signed [15:0] word_x;
        logic [1:0]         frame_kind;
    } result_t;

endpackage

// ===== design/ifp_in_reg.sv =====
// Input register holding one received byte until the parser takes it.
`timescale 1ns / 1ps

module ifp_in_reg (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,
    input  logic       take,
    output logic       byte_valid,
    output logic [7:0] byte_data
);
    import ifp_pkg::*;

    logic       valid_reg, valid_next;
    logic [7:0] data_reg;

    assign s_tready   = !valid_reg || take;
    assign byte_valid = valid_reg;
    assign byte_data  = data_reg;

    always_comb begin
        valid_next = valid_reg;
        if (s_tready) begin
            valid_next = s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            data_reg <= s_tdata;
        end
    end

endmodule

// ===== design/ifp_parser.sv =====
// Frame state machine, running checksum, payload bytes and type filter.
`timescale 1ns / 1ps

module ifp_parser (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_valid,
    input  logic [7:0]       cfg_data,
    input  logic             take,
    input  logic [7:0]       byte_data,
    output logic             res_valid,
    output ifp_pkg::result_t res
);
    import ifp_pkg::*;

    phase_t     phase_reg, phase_next;
    logic [3:0] pos_reg, pos_next;
    logic [1:0] kind_reg, kind_next;
    logic [7:0] sum_reg, sum_next;
    logic [7:0] filter_reg;
    logic [7:0] payload_reg [NUM_PAYLOAD];
    logic [2:0] wr_idx;
    logic       wr_en;
    logic       type_ok;
    logic       hit;

    assign type_ok = (byte_data == KIND_ACC) || (byte_data == KIND_GYRO)
                     || (byte_data == KIND_ANGLE);
    assign wr_idx  = 3'(pos_reg - POS_FIRST_DATA);

    always_comb begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        kind_next  = kind_reg;
        sum_next   = sum_reg;
        wr_en      = 1'b0;
        hit        = 1'b0;
        unique case (phase_reg)
            PH_TYPE: begin
                if (type_ok && (filter_reg == 8'd0 || byte_data == filter_reg)) begin
                    kind_next  = 2'(byte_data - KIND_ACC);
                    sum_next   = sum_reg + byte_data;
                    pos_next   = POS_FIRST_DATA;
                    phase_next = PH_DATA;
                end else begin
                    phase_next = PH_HUNT;
                end
            end
            PH_DATA: begin
                if (pos_reg >= POS_CHECKSUM) begin
                    phase_next = PH_HUNT;
                    pos_next   = 4'd0;
                    hit        = (byte_data == sum_reg);
                end else begin
                    wr_en    = 1'b1;
                    sum_next = sum_reg + byte_data;
                    pos_next = pos_reg + 4'd1;
                end
            end
            default: begin
                phase_next = PH_HUNT;
                if (byte_data == HDR_BYTE) begin
                    sum_next   = byte_data;
                    pos_next   = 4'd1;
                    phase_next = PH_TYPE;
                end
            end
        endcase
    end

    assign res_valid      = take && hit;
    assign res.frame_kind = kind_reg;
    assign res.word_x     = {payload_reg[1], payload_reg[0]};
    assign res.word_y     = {payload_reg[3], payload_reg[2]};
    assign res.word_z     = {payload_reg[5], payload_reg[4]};
    assign res.word_extra = {payload_reg[7], payload_reg[6]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_HUNT;
            pos_reg    <= 4'd0;
            kind_reg   <= 2'd0;
            sum_reg    <= 8'd0;
            filter_reg <= 8'd0;
        end else begin
            if (take) begin
                phase_reg <= phase_next;
                pos_reg   <= pos_next;
                kind_reg  <= kind_next;
                sum_reg   <= sum_next;
            end
            if (cfg_valid) begin
                filter_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take && wr_en) begin
            payload_reg[wr_idx] <= byte_data;
        end
    end

    a_hit_at_checksum: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |-> (phase_reg == PH_DATA) && (pos_reg == POS_CHECKSUM))
        else $error("result outside checksum byte");

    a_data_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_DATA) |-> (pos_reg >= POS_FIRST_DATA) && (pos_reg <= POS_CHECKSUM))
        else $error("byte position out of frame");

    a_type_after_hdr: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_TYPE) |-> (sum_reg == HDR_BYTE) && (pos_reg == 4'd1))
        else $error("type phase without header");

endmodule

// ===== design/ifp_out_reg.sv =====
// Result register toward the output stream.
`timescale 1ns / 1ps

module ifp_out_reg (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             load,
    input  ifp_pkg::result_t res,
    output logic             free,
    output logic             m_tvalid,
    input  logic             m_tready,
    output ifp_pkg::result_t res_out
);
    import ifp_pkg::*;

    logic    valid_reg, valid_next;
    result_t res_reg;

    assign free     = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;
    assign res_out  = res_reg;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= res;
        end
    end

endmodule

// ===== design/imu_frame_parser.sv =====
// Top level of the IMU frame parser: byte stream in, decoded frames out.
//
// Takes one serial byte per cycle and finds 11-byte frames (header 0x55, type
// 0x51/0x52/0x53, eight data bytes, sum checksum). A good frame gives one
// output item with its kind and four signed little-endian words; a bad or
// filtered frame gives nothing. Sustained rate is one byte per cycle while the
// output is not stalled, as the phase, position and running-sum registers
// update for each byte. m_tvalid rises after the checksum byte is accepted: the
// byte sits in the input register, then the result register loads.
// While a result waits with m_tready low, the input stalls.
// type_filter 0 passes every kind.
`timescale 1ns / 1ps

module imu_frame_parser (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data,    // type_filter
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,     // rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,     // word_x, word_y, word_z, word_extra
    output logic [1:0]  m_tuser      // frame_kind
);
    import ifp_pkg::*;

    logic       byte_valid;
    logic [7:0] byte_data;
    logic       take;
    logic       out_free;
    logic       res_valid;
    result_t    res;
    result_t    res_out;

    assign cfg_ready = 1'b1;
    assign take      = byte_valid && out_free;

    ifp_in_reg u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .take       (take),
        .byte_valid (byte_valid),
        .byte_data  (byte_data)
    );

    ifp_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .take      (take),
        .byte_data (byte_data),
        .res_valid (res_valid),
        .res       (res)
    );

    ifp_out_reg u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (res_valid),
        .res      (res),
        .free     (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .res_out  (res_out)
    );

    assign m_tuser = res_out.frame_kind;
    assign m_tdata = {res_out.word_extra, res_out.word_z, res_out.word_y, res_out.word_x};

endmodule
